@@ rtl/core/hsvc_pkg.sv @@
// Shared types and constants for the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsvc_pkg;

    localparam int CH_W    = 15;
    localparam int FRAC_W  = 12;
    localparam int PROD_W  = 30;
    localparam int XPROD_W = 42;
    localparam int XSUM_W  = 43;
    localparam int QUO_W   = 19;
    localparam int MQ_W    = 16;

    localparam logic signed [16:0] HUE_TURN   = 17'sd23040;
    localparam int                 HUE_SECTOR = 3840;
    localparam logic [12:0]        RECIP15    = 13'd4369;

    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } t_sector;

    typedef struct packed {
        logic signed [15:0] hue;
        logic signed [15:0] saturation;
        logic signed [15:0] brightness;
    } t_hsv_in;

    typedef struct packed {
        logic [14:0] red;
        logic [14:0] green;
        logic [14:0] blue;
    } t_rgb_out;

    typedef struct packed {
        logic [CH_W-1:0]   val;
        logic [CH_W-1:0]   sat;
        logic [FRAC_W-1:0] frac;
        t_sector           sector;
        logic              gray;
    } t_entry;

endpackage

`default_nettype wire

@@ rtl/core/hsvc_front.sv @@
// Input register, hue wrap, clamping and sector classification.
`timescale 1ns / 1ps
`default_nettype none

module hsvc_front #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire hsvc_pkg::t_hsv_in i_hsv,
    input  wire logic             i_q_full,
    output logic                  busy,
    output logic                  o_push,
    output hsvc_pkg::t_entry      o_entry
);

    localparam logic [17:0] ONE_U = 18'(1) << FRAC_BITS;
    localparam int          SEC   = hsvc_pkg::HUE_SECTOR;

    logic                r_valid;
    logic                n_valid;
    hsvc_pkg::t_hsv_in   r_in;
    logic signed [16:0]  h;
    logic [14:0]         hw;
    logic [14:0]         base;
    hsvc_pkg::t_sector   sector;

    function automatic logic [14:0] clamp_unit(input logic signed [15:0] x);
        logic [14:0] res;
        if (x[15]) begin
            res = '0;
        end else if ({2'b00, x} > ONE_U) begin
            res = ONE_U[14:0];
        end else begin
            res = x[14:0];
        end
        return res;
    endfunction

    assign busy   = r_valid && i_q_full;
    assign o_push = r_valid && !i_q_full;

    always_comb begin
        n_valid = r_valid;
        if (!busy) begin
            n_valid = start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (start && !busy) begin
            r_in <= i_hsv;
        end
    end

    always_comb begin
        h = 17'(r_in.hue);
        for (int k = 0; k < 2; k++) begin
            if (h >= hsvc_pkg::HUE_TURN) begin
                h = h - hsvc_pkg::HUE_TURN;
            end
            if (h < 17'sd0) begin
                h = h + hsvc_pkg::HUE_TURN;
            end
        end
        hw = h[14:0];
    end

    always_comb begin
        if (hw >= 15'(5 * SEC)) begin
            sector = hsvc_pkg::SEC_M_R;
            base   = 15'(5 * SEC);
        end else if (hw >= 15'(4 * SEC)) begin
            sector = hsvc_pkg::SEC_B_M;
            base   = 15'(4 * SEC);
        end else if (hw >= 15'(3 * SEC)) begin
            sector = hsvc_pkg::SEC_C_B;
            base   = 15'(3 * SEC);
        end else if (hw >= 15'(2 * SEC)) begin
            sector = hsvc_pkg::SEC_G_C;
            base   = 15'(2 * SEC);
        end else if (hw >= 15'(SEC)) begin
            sector = hsvc_pkg::SEC_Y_G;
            base   = 15'(SEC);
        end else begin
            sector = hsvc_pkg::SEC_R_Y;
            base   = '0;
        end
    end

    always_comb begin
        o_entry.val    = clamp_unit(r_in.brightness);
        o_entry.sat    = clamp_unit(r_in.saturation);
        o_entry.frac   = 12'(hw - base);
        o_entry.sector = sector;
        o_entry.gray   = (o_entry.sat == '0);
    end

endmodule

`default_nettype wire

@@ rtl/core/hsvc_queue.sv @@
// Short register queue between the classifying front and the arithmetic back.
`timescale 1ns / 1ps
`default_nettype none

module hsvc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire hsvc_pkg::t_entry i_entry,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output hsvc_pkg::t_entry     o_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hsvc_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/hsvc_back.sv @@
// Five-stage pipeline that forms p, q and t and routes them by sector.
`timescale 1ns / 1ps
`default_nettype none

module hsvc_back #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire hsvc_pkg::t_entry i_entry,
    output logic                 o_valid,
    output hsvc_pkg::t_rgb_out   o_rgb
);

    localparam logic [16:0] ONE17    = 17'(1) << FRAC_BITS;
    localparam logic [32:0] HALF_ONE = 33'(1) << (FRAC_BITS - 1);
    localparam logic [hsvc_pkg::XSUM_W-1:0] HALF_DEN_M1 =
        (hsvc_pkg::XSUM_W'(1920) << FRAC_BITS) - 1'b1;
    localparam logic [11:0] SEC12 = 12'(hsvc_pkg::HUE_SECTOR);

    typedef struct packed {
        logic [14:0]         v;
        hsvc_pkg::t_sector   sector;
        logic                gray;
    } t_side;

    logic                            r_v1, r_v2, r_v3, r_v4, r_vo;
    t_side                           r_sd1, r_sd2, r_sd3, r_sd4;
    logic [hsvc_pkg::PROD_W-1:0]     r_vs;
    logic [31:0]                     r_pm;
    logic [11:0]                     r_frac;
    logic [hsvc_pkg::XPROD_W-1:0]    r_xq, r_xt;
    logic [14:0]                     r_p2, r_p3, r_p4;
    logic [hsvc_pkg::QUO_W-1:0]      r_yq3, r_yt3, r_yq4, r_yt4;
    logic [hsvc_pkg::MQ_W-1:0]       r_mq, r_mt;
    hsvc_pkg::t_rgb_out              r_rgb;

    logic [32:0]                     p_sum;
    logic [hsvc_pkg::XSUM_W-1:0]     q_sum, t_sum;
    logic [31:0]                     q_rec, t_rec;
    logic [14:0]                     q_val, t_val;
    hsvc_pkg::t_rgb_out              n_rgb;

    function automatic logic [14:0] div15_sub(
        input logic [14:0]                  v,
        input logic [hsvc_pkg::QUO_W-1:0]   y,
        input logic [hsvc_pkg::MQ_W-1:0]    m
    );
        logic [hsvc_pkg::QUO_W-1:0] m15;
        logic [hsvc_pkg::QUO_W-1:0] rem;
        logic [hsvc_pkg::MQ_W-1:0]  quot;
        m15  = (hsvc_pkg::QUO_W'(m) << 4) - hsvc_pkg::QUO_W'(m);
        rem  = y - m15;
        quot = m + hsvc_pkg::MQ_W'(rem >= hsvc_pkg::QUO_W'(15));
        return v - quot[14:0];
    endfunction

    assign p_sum = {1'b0, r_pm} + HALF_ONE;
    assign q_sum = hsvc_pkg::XSUM_W'(r_xq) + HALF_DEN_M1;
    assign t_sum = hsvc_pkg::XSUM_W'(r_xt) + HALF_DEN_M1;
    assign q_rec = 32'(r_yq3) * 32'(hsvc_pkg::RECIP15);
    assign t_rec = 32'(r_yt3) * 32'(hsvc_pkg::RECIP15);
    assign q_val = div15_sub(r_sd4.v, r_yq4, r_mq);
    assign t_val = div15_sub(r_sd4.v, r_yt4, r_mt);

    always_comb begin
        case (r_sd4.sector)
            hsvc_pkg::SEC_R_Y: n_rgb = '{red: r_sd4.v, green: t_val,   blue: r_p4};
            hsvc_pkg::SEC_Y_G: n_rgb = '{red: q_val,   green: r_sd4.v, blue: r_p4};
            hsvc_pkg::SEC_G_C: n_rgb = '{red: r_p4,    green: r_sd4.v, blue: t_val};
            hsvc_pkg::SEC_C_B: n_rgb = '{red: r_p4,    green: q_val,   blue: r_sd4.v};
            hsvc_pkg::SEC_B_M: n_rgb = '{red: t_val,   green: r_p4,    blue: r_sd4.v};
            default:           n_rgb = '{red: r_sd4.v, green: r_p4,    blue: q_val};
        endcase
        if (r_sd4.gray) begin
            n_rgb = '{red: r_sd4.v, green: r_sd4.v, blue: r_sd4.v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_vo <= r_v4;
        end
        r_sd1  <= '{v: i_entry.val, sector: i_entry.sector, gray: i_entry.gray};
        r_frac <= i_entry.frac;
        r_vs   <= hsvc_pkg::PROD_W'(i_entry.val) * hsvc_pkg::PROD_W'(i_entry.sat);
        r_pm   <= 32'(i_entry.val) * 32'(ONE17 - {2'b00, i_entry.sat});

        r_sd2 <= r_sd1;
        r_xq  <= hsvc_pkg::XPROD_W'(r_vs) * hsvc_pkg::XPROD_W'(r_frac);
        r_xt  <= hsvc_pkg::XPROD_W'(r_vs) * hsvc_pkg::XPROD_W'(SEC12 - r_frac);
        r_p2  <= p_sum[FRAC_BITS +: 15];

        r_sd3 <= r_sd2;
        r_p3  <= r_p2;
        r_yq3 <= q_sum[FRAC_BITS + 8 +: hsvc_pkg::QUO_W];
        r_yt3 <= t_sum[FRAC_BITS + 8 +: hsvc_pkg::QUO_W];

        r_sd4 <= r_sd3;
        r_p4  <= r_p3;
        r_yq4 <= r_yq3;
        r_yt4 <= r_yt3;
        r_mq  <= q_rec[31:16];
        r_mt  <= t_rec[31:16];

        r_rgb <= n_rgb;
    end

    assign o_valid = r_vo;
    assign o_rgb   = r_rgb;

endmodule

`default_nettype wire

@@ rtl/core/hsv_to_rgb_converter.sv @@
// Top level of the HSV to RGB converter: front, queue and arithmetic back.
`timescale 1ns / 1ps
`default_nettype none

// One color beat is taken per clock whenever busy is low, and each beat gives
// one RGB beat on o_rgb, marked by o_valid for a single cycle. Each beat takes
// the input register, one pass through the queue and the five-stage multiply
// pipeline that forms and rounds p, q and t. The receiver cannot stall, so the
// queue never fills and busy stays low in normal use.
module hsv_to_rgb_converter #(
    parameter int FRAC_BITS   = 14,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire hsvc_pkg::t_hsv_in i_hsv,
    output logic                   busy,
    output logic                   o_valid,
    output hsvc_pkg::t_rgb_out     o_rgb
);

    localparam logic [14:0] CH_MAX = (FRAC_BITS >= 15) ? 15'h7FFF : 15'(1 << FRAC_BITS);

    logic             q_full;
    logic             q_empty;
    logic             push;
    hsvc_pkg::t_entry front_entry;
    hsvc_pkg::t_entry back_entry;

    hsvc_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_hsv   (i_hsv),
        .i_q_full(q_full),
        .busy    (busy),
        .o_push  (push),
        .o_entry (front_entry)
    );

    hsvc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(front_entry),
        .i_pop  (!q_empty),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_entry(back_entry)
    );

    hsvc_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(!q_empty),
        .i_entry(back_entry),
        .o_valid(o_valid),
        .o_rgb  (o_rgb)
    );

    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_valid)
        else $error("Accepted beat did not produce a result on time.");

    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 7))
        else $error("Result beat without a matching input beat.");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rgb.red <= CH_MAX && o_rgb.green <= CH_MAX && o_rgb.blue <= CH_MAX))
        else $error("Output channel above full scale.");

endmodule

`default_nettype wire
